>>> src/sered_pkg.sv
// shared types and constants for the scintillation event record decoder
package sered_pkg;

	// one complete record, byte 0 in the top eight bits
	localparam int RecordBytes = 16;
	localparam int RecordWidth = 8 * RecordBytes;
	typedef logic [RecordWidth-1:0] rec_t;

	// header byte marker in the top five bits
	localparam logic [4:0] HeaderMark = 5'h1F;

	// byte position of the last byte of a record
	localparam logic [3:0] LastPos = 4'(RecordBytes - 1);

	// reset value of the tag period register
	localparam logic [19:0] PeriodReset = 20'd80000;

	// record transaction between front, queue and back
	typedef struct packed {
		logic valid;
		rec_t rec;
	} rec_chan_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PREP,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// pick byte idx (0 = header) out of a record
	function automatic logic [7:0] rec_byte(input rec_t rec, input int idx);
		rec_byte = rec[RecordWidth-1-8*idx -: 8];
	endfunction

endpackage

>>> src/scintillation_event_record_decoder.sv
// Scintillation event record decoder. Takes the detector byte stream at one byte
// per clock, drops bytes until a header (top five bits set), then gathers the
// header and fifteen more bytes into a record. A time-tag record updates the
// 48-bit tag of its module and gives no output; an event record gives one result
// with block number, both energy sums, the x and y anger ratios and the absolute
// time. Assembled records go through a two-record queue to the back end, which
// takes a time-tag record straight off the queue head and runs an event record
// through prepare, divide (two quotient bits per step) and done, so a 16-byte
// record is finished well before the next arrives and the input runs at one byte
// per clock as long as results are taken. With the back end idle, a record's last
// byte passes the queue, capture, prepare, divide, done and the result register
// before its result is offered. The user must write tag_period_ticks through
// the config channel only while the block is idle; not enforced. Resets to 80000.
module scintillation_event_record_decoder #(
	parameter int MODULE_COUNT        = 16,
	parameter int RATIO_FRACTION_BITS = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] tag_period_ticks,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  block_id,
	output logic [13:0] energy_first,
	output logic [13:0] energy_second,
	output logic [15:0] x_ratio,
	output logic [15:0] y_ratio,
	output logic [63:0] event_time
);

	logic [19:0]          period_q;
	sered_pkg::rec_chan_t push;
	sered_pkg::rec_chan_t head;
	logic                 q_full;
	logic                 pop;

	// tag period register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= sered_pkg::PeriodReset;
		end else if (cfg_valid && cfg_ready) begin
			period_q <= tag_period_ticks;
		end
	end

	// header hunt and record assembly
	sered_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push)
	);

	// record queue
	sered_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// decode and compute
	sered_back #(
		.MODULE_COUNT        (MODULE_COUNT),
		.RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.period        (period_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.block_id      (block_id),
		.energy_first  (energy_first),
		.energy_second (energy_second),
		.x_ratio       (x_ratio),
		.y_ratio       (y_ratio),
		.event_time    (event_time)
	);

endmodule

>>> src/sered_front.sv
// front end: header hunt and record assembly
module sered_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 q_full,
	output sered_pkg::rec_chan_t push
);

	logic       in_frame_q;
	logic [3:0] pos_q;
	logic [7:0] bytes_q [sered_pkg::RecordBytes-1];
	logic       accept;
	logic       is_header;
	logic       last_byte;

	// hold the input whenever the queue has no room
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign is_header = (data_byte[7:3] == sered_pkg::HeaderMark);
	assign last_byte = in_frame_q && (pos_q == sered_pkg::LastPos);

	// framing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= 4'd0;
		end else if (accept) begin
			if (!in_frame_q) begin
				if (is_header) begin
					in_frame_q <= 1'b1;
					pos_q      <= 4'd1;
				end
			end else if (last_byte) begin
				in_frame_q <= 1'b0;
				pos_q      <= 4'd0;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// record byte store
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!in_frame_q) begin
				if (is_header) begin
					bytes_q[0] <= data_byte;
				end
			end else if (!last_byte) begin
				bytes_q[pos_q] <= data_byte;
			end
		end
	end

	// full record out on the last byte
	always_comb begin
		push.valid = accept && last_byte;
		push.rec   = '0;
		for (int i = 0; i < sered_pkg::RecordBytes - 1; i++) begin
			push.rec[sered_pkg::RecordWidth-1-8*i -: 8] = bytes_q[i];
		end
		push.rec[7:0] = data_byte;
	end

endmodule

>>> src/sered_fifo.sv
// two-entry record queue between front and back
module sered_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sered_pkg::rec_chan_t push,
	output logic                 full,
	output sered_pkg::rec_chan_t head,
	input  logic                 pop
);

	sered_pkg::rec_t mem_q [2];
	logic            wr_q;
	logic            rd_q;
	logic [1:0]      cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head.valid = (cnt_q != 2'd0);
	assign head.rec   = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push.valid) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_q] <= push.rec;
		end
	end

endmodule

>>> src/sered_div.sv
// radix-4 restoring divider for one anger ratio
module sered_div #(
	parameter int FRAC_BITS = 15
) (
	input  logic        clk,
	input  logic        start,
	input  logic        step,
	input  logic [12:0] num,
	input  logic [13:0] sum,
	output logic [15:0] ratio
);

	// fraction bits rounded up to even, plus the integer bit
	localparam int FB = 2 * ((FRAC_BITS + 1) / 2);
	localparam int QW = FB + 1;
	localparam int WW = (QW > 17) ? QW : 17;

	logic          zero_q;
	logic [13:0]   rem_q;
	logic [QW-1:0] quot_q;
	logic [14:0]   t1;
	logic [14:0]   t2;
	logic [14:0]   sum_x;
	logic          ge1;
	logic          ge2;
	logic [13:0]   r1;
	logic [13:0]   r2;
	logic [WW-1:0] shifted;
	logic [WW-1:0] raw;

	// two quotient bits per step
	always_comb begin
		sum_x = {1'b0, sum};
		t1    = {rem_q, 1'b0};
		ge1   = (t1 >= sum_x);
		r1    = ge1 ? 14'(t1 - sum_x) : t1[13:0];
		t2    = {r1, 1'b0};
		ge2   = (t2 >= sum_x);
		r2    = ge2 ? 14'(t2 - sum_x) : t2[13:0];
	end

	// integer bit on start, fraction bits on each step
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (sum == 14'd0);
			if ({1'b0, num} >= sum) begin
				quot_q <= QW'(1);
				rem_q  <= 14'({1'b0, num} - sum);
			end else begin
				quot_q <= '0;
				rem_q  <= {1'b0, num};
			end
		end else if (step) begin
			quot_q <= {quot_q[QW-3:0], ge1, ge2};
			rem_q  <= r2;
		end
	end

	// drop the extra bit, zero-sum case, saturate to 16 bits
	always_comb begin
		shifted = WW'(quot_q >> (FB - FRAC_BITS));
		raw     = zero_q ? (WW'(1) << FRAC_BITS) : shifted;
		ratio   = (raw > WW'(16'hFFFF)) ? 16'hFFFF : raw[15:0];
	end

endmodule

>>> src/sered_back.sv
// back end: record decode, tag store, ratios, time and result register
module sered_back #(
	parameter int MODULE_COUNT        = 16,
	parameter int RATIO_FRACTION_BITS = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sered_pkg::rec_chan_t head,
	output logic                 pop,
	input  logic [19:0]          period,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [5:0]           block_id,
	output logic [13:0]          energy_first,
	output logic [13:0]          energy_second,
	output logic [15:0]          x_ratio,
	output logic [15:0]          y_ratio,
	output logic [63:0]          event_time
);

	localparam int MOD_W = (MODULE_COUNT > 1) ? $clog2(MODULE_COUNT) : 1;
	localparam int STEPS = (RATIO_FRACTION_BITS + 1) / 2;
	localparam int CNT_W = $clog2(STEPS);

	sered_pkg::back_state_t state_q;
	sered_pkg::back_state_t state_d;

	// decoded fields of the queue head
	logic [7:0]  d [sered_pkg::RecordBytes];
	logic [5:0]  blk;
	logic        is_event;
	logic [3:0]  mod;
	logic        mod_ok;
	logic [MOD_W-1:0] mod_idx;
	logic [11:0] ch_a, ch_b, ch_c, ch_d, ch_e, ch_f, ch_g, ch_h;
	logic [47:0] new_tag;
	logic [19:0] fine;

	// sequencer controls
	logic tag_we;
	logic capture;
	logic div_start;
	logic div_step;
	logic out_load;

	// stored and working registers
	logic [47:0]      tags_q [MODULE_COUNT];
	logic [5:0]       blk_q;
	logic [13:0]      sum1_q;
	logic [13:0]      sum2_q;
	logic [12:0]      num_x_q;
	logic [12:0]      num_y_q;
	logic [19:0]      fine_q;
	logic [47:0]      tag_q;
	logic [43:0]      prod_hi_q;
	logic [43:0]      prod_lo_q;
	logic [63:0]      mid_q;
	logic [63:0]      time_q;
	logic [CNT_W-1:0] step_q;
	logic [15:0]      ratio_x;
	logic [15:0]      ratio_y;
	logic             out_valid_q;

	// unpack the head record
	always_comb begin
		for (int i = 0; i < sered_pkg::RecordBytes; i++) begin
			d[i] = sered_pkg::rec_byte(head.rec, i);
		end
		blk      = {d[0][1:0], d[1][7:4]};
		is_event = d[0][2];
		mod      = blk[5:2];
		mod_ok   = ({1'b0, mod} < 5'(MODULE_COUNT));
		mod_idx  = mod[MOD_W-1:0];
		ch_a     = {d[1][3:0], d[2]};
		ch_c     = {d[4][3:0], d[5]};
		ch_e     = {d[7][3:0], d[8]};
		ch_g     = {d[10][3:0], d[11]};
		ch_b     = {d[3], d[4][7:4]};
		ch_d     = {d[6], d[7][7:4]};
		ch_f     = {d[9], d[10][7:4]};
		ch_h     = {d[12], d[13][7:4]};
		new_tag  = {d[10], d[11], d[12], d[13], d[14], d[15]};
		fine     = {d[13][3:0], d[14], d[15]};
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sered_pkg::BK_IDLE: begin
				if (head.valid && is_event) begin
					state_d = sered_pkg::BK_PREP;
				end
			end
			sered_pkg::BK_PREP: state_d = sered_pkg::BK_DIV;
			sered_pkg::BK_DIV: begin
				if (step_q == '0) begin
					state_d = sered_pkg::BK_DONE;
				end
			end
			sered_pkg::BK_DONE: begin
				if (out_load) begin
					state_d = sered_pkg::BK_IDLE;
				end
			end
			default: state_d = sered_pkg::BK_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		pop       = (state_q == sered_pkg::BK_IDLE) && head.valid;
		tag_we    = pop && !is_event && mod_ok;
		capture   = pop && is_event;
		div_start = (state_q == sered_pkg::BK_PREP);
		div_step  = (state_q == sered_pkg::BK_DIV);
		out_load  = (state_q == sered_pkg::BK_DONE) && (!out_valid_q || out_ready);
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sered_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// per-module time tags, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MODULE_COUNT; i++) begin
				tags_q[i] <= '0;
			end
		end else if (tag_we) begin
			tags_q[mod_idx] <= new_tag;
		end
	end

	// event capture: sums, ratio numerators, fine time, module tag
	always_ff @(posedge clk) begin
		if (capture) begin
			blk_q   <= blk;
			sum1_q  <= 14'(ch_a) + 14'(ch_b) + 14'(ch_c) + 14'(ch_d);
			sum2_q  <= 14'(ch_e) + 14'(ch_f) + 14'(ch_g) + 14'(ch_h);
			num_x_q <= 13'(ch_a) + 13'(ch_b);
			num_y_q <= 13'(ch_a) + 13'(ch_d);
			fine_q  <= fine;
			tag_q   <= mod_ok ? tags_q[mod_idx] : 48'd0;
		end
	end

	// tag times period as two 24 by 20 partial products, then two adds
	always_ff @(posedge clk) begin
		if (div_start) begin
			prod_hi_q <= tag_q[47:24] * period;
			prod_lo_q <= tag_q[23:0] * period;
		end
		if (div_step) begin
			mid_q  <= {prod_hi_q[39:0], 24'd0} + {20'd0, prod_lo_q};
			time_q <= mid_q + {44'd0, fine_q};
		end
	end

	// divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (div_start) begin
			step_q <= CNT_W'(STEPS - 1);
		end else if (div_step) begin
			step_q <= step_q - 1'b1;
		end
	end

	// x and y ratio dividers run side by side
	sered_div #(
		.FRAC_BITS(RATIO_FRACTION_BITS)
	) u_div_x (
		.clk   (clk),
		.start (div_start),
		.step  (div_step),
		.num   (num_x_q),
		.sum   (sum1_q),
		.ratio (ratio_x)
	);

	sered_div #(
		.FRAC_BITS(RATIO_FRACTION_BITS)
	) u_div_y (
		.clk   (clk),
		.start (div_start),
		.step  (div_step),
		.num   (num_y_q),
		.sum   (sum1_q),
		.ratio (ratio_y)
	);

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			block_id      <= blk_q;
			energy_first  <= sum1_q;
			energy_second <= sum2_q;
			x_ratio       <= ratio_x;
			y_ratio       <= ratio_y;
			event_time    <= time_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the scintillation event record decoder
`timescale 1ns / 1ps

module tb_top;

	localparam int ModuleCount = 16;
	localparam int RatioFracBits = 15;
	localparam int DrainCycles = 40;
	localparam int LongHold = 400;
	localparam int StallLimit = 3000;
	localparam int PhaseCount = 6;

	// byte 0 (the header) is element 0
	typedef logic [0:15][7:0] frame_t;

	typedef struct packed {
		logic [5:0]  block;
		logic [13:0] energy_first;
		logic [13:0] energy_second;
		logic [15:0] x_ratio;
		logic [15:0] y_ratio;
		logic [63:0] event_time;
	} event_result_t;

	// predicts decoded events from the accepted byte stream and checks the results
	class event_scoreboard;
		logic [19:0]   period;
		bit            in_frame;
		logic [3:0]    pos;
		frame_t        rec;
		logic [47:0]   tags [ModuleCount];
		event_result_t expected_events [$];
		int            events_predicted;
		int            mismatches;

		function new();
			period = sered_pkg::PeriodReset;
			in_frame = 1'b0;
			pos = '0;
			rec = '0;
			foreach (tags[i])
				tags[i] = '0;
			events_predicted = 0;
			mismatches = 0;
		endfunction

		function void set_period(logic [19:0] p);
			period = p;
		endfunction

		function int pending();
			return expected_events.size();
		endfunction

		function int failures();
			return mismatches + expected_events.size();
		endfunction

		function logic [15:0] anger_ratio(logic [13:0] part, logic [13:0] total);
			logic [63:0] q;
			if (total == 0)
				return 16'(1 << RatioFracBits);
			q = (64'(part) << RatioFracBits) / 64'(total);
			return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
		endfunction

		// time tags update the module store, event records give one result
		function void decode_record();
			logic [5:0]    blk;
			logic [3:0]    mdl;
			logic [47:0]   tag;
			logic [11:0]   a, b, c, d, e, f, g, h;
			logic [19:0]   fine;
			event_result_t r;
			blk = {rec[0][1:0], rec[1][7:4]};
			mdl = blk[5:2];
			tag = (int'(mdl) < ModuleCount) ? tags[mdl] : '0;
			if (!rec[0][2]) begin
				if (int'(mdl) < ModuleCount)
					tags[mdl] = {rec[10], rec[11], rec[12], rec[13], rec[14], rec[15]};
				return;
			end
			a = {rec[1][3:0], rec[2]};
			b = {rec[3], rec[4][7:4]};
			c = {rec[4][3:0], rec[5]};
			d = {rec[6], rec[7][7:4]};
			e = {rec[7][3:0], rec[8]};
			f = {rec[9], rec[10][7:4]};
			g = {rec[10][3:0], rec[11]};
			h = {rec[12], rec[13][7:4]};
			fine = {rec[13][3:0], rec[14], rec[15]};
			r.block = blk;
			r.energy_first = 14'(a) + 14'(b) + 14'(c) + 14'(d);
			r.energy_second = 14'(e) + 14'(f) + 14'(g) + 14'(h);
			r.x_ratio = anger_ratio(14'(a) + 14'(b), r.energy_first);
			r.y_ratio = anger_ratio(14'(a) + 14'(d), r.energy_first);
			r.event_time = 64'(tag) * 64'(period) + 64'(fine);
			expected_events.insert(expected_events.size(), r);
			events_predicted++;
		endfunction

		// one accepted input transaction: hunt, gather, decode on the last byte
		function void note_byte(logic [7:0] data);
			if (!in_frame) begin
				if (data[7:3] == sered_pkg::HeaderMark) begin
					rec[0] = data;
					pos = 4'd1;
					in_frame = 1'b1;
				end
			end else if (pos != sered_pkg::LastPos) begin
				rec[pos] = data;
				pos = pos + 4'd1;
			end else begin
				rec[sered_pkg::LastPos] = data;
				in_frame = 1'b0;
				pos = '0;
				decode_record();
			end
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name,
						want, got);
			end
		endfunction

		// one output transaction against the oldest expected event
		function void check_result(event_result_t got);
			event_result_t want;
			if (expected_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no event pending, block %0d", $realtime,
						got.block);
				return;
			end
			want = expected_events.pop_front();
			check_field("block_id", 64'(want.block), 64'(got.block));
			check_field("energy_first", 64'(want.energy_first), 64'(got.energy_first));
			check_field("energy_second", 64'(want.energy_second), 64'(got.energy_second));
			check_field("x_ratio", 64'(want.x_ratio), 64'(got.x_ratio));
			check_field("y_ratio", 64'(want.y_ratio), 64'(got.y_ratio));
			check_field("event_time", want.event_time, got.event_time);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  data_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [19:0] tag_period_ticks;
	logic        out_valid;
	logic        out_ready;
	logic [5:0]  block_id;
	logic [13:0] energy_first;
	logic [13:0] energy_second;
	logic [15:0] x_ratio;
	logic [15:0] y_ratio;
	logic [63:0] event_time;

	event_scoreboard sb = new();
	bit quiet;
	int hold_requests;
	int idle_cycles = 0;

	scintillation_event_record_decoder dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.data_byte        (data_byte),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.tag_period_ticks (tag_period_ticks),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.block_id         (block_id),
		.energy_first     (energy_first),
		.energy_second    (energy_second),
		.x_ratio          (x_ratio),
		.y_ratio          (y_ratio),
		.event_time       (event_time)
	);

	always #6 clk = ~clk;

	// check every output transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({block_id, energy_first, energy_second, x_ratio, y_ratio,
				event_time});
	end

	// end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall bursts, plus long hold-offs on request
	initial begin : receiver
		int stall_left;
		int holds_served;
		stall_left = 0;
		holds_served = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_served != hold_requests) begin
				holds_served = hold_requests;
				stall_left = LongHold;
			end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 7);
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// event record from eight channels A..H (A in element 0) and a fine time
	function automatic frame_t event_frame(logic [5:0] blk, logic [7:0][11:0] ch,
		logic [19:0] fine);
		frame_t f;
		f[0] = {sered_pkg::HeaderMark, 1'b1, blk[5:4]};
		f[1] = {blk[3:0], ch[0][11:8]};
		f[2] = ch[0][7:0];
		f[3] = ch[1][11:4];
		f[4] = {ch[1][3:0], ch[2][11:8]};
		f[5] = ch[2][7:0];
		f[6] = ch[3][11:4];
		f[7] = {ch[3][3:0], ch[4][11:8]};
		f[8] = ch[4][7:0];
		f[9] = ch[5][11:4];
		f[10] = {ch[5][3:0], ch[6][11:8]};
		f[11] = ch[6][7:0];
		f[12] = ch[7][11:4];
		f[13] = {ch[7][3:0], fine[19:16]};
		f[14] = fine[15:8];
		f[15] = fine[7:0];
		return f;
	endfunction

	// time-tag record, filler bytes random
	function automatic frame_t tag_frame(logic [5:0] blk, logic [47:0] tag);
		frame_t f;
		f[0] = {sered_pkg::HeaderMark, 1'b0, blk[5:4]};
		f[1] = {blk[3:0], 4'($urandom)};
		for (int i = 2; i < 10; i++)
			f[i] = 8'($urandom);
		for (int i = 0; i < 6; i++)
			f[10 + i] = tag[47 - 8 * i -: 8];
		return f;
	endfunction

	// channel sets: random, full scale, empty first sum, tiny, sparse
	function automatic logic [7:0][11:0] pick_channels();
		logic [7:0][11:0] ch;
		int mode;
		mode = $urandom_range(0, 6);
		for (int i = 0; i < 8; i++) begin
			case (mode)
				2: ch[i] = 12'hFFF;
				3: ch[i] = (i < 4) ? 12'h000 : 12'($urandom);
				4: ch[i] = 12'($urandom_range(0, 3));
				5: ch[i] = (i == 0 || i == 2) ? 12'($urandom) : 12'h000;
				default: ch[i] = 12'($urandom);
			endcase
		end
		return ch;
	endfunction

	function automatic logic [47:0] pick_tag();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {16'($urandom), 32'($urandom)};
		endcase
	endfunction

	// one input transaction; called and returning at a falling edge
	task automatic send_byte(input logic [7:0] data);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= data;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_byte(data);
		@(negedge clk);
	endtask

	task automatic send_frame(input frame_t f);
		for (int i = 0; i < 16; i++)
			send_byte(f[i]);
	endtask

	// stop input, wait for every expected event, then let the back end settle
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_period(input logic [19:0] p);
		cfg_valid <= 1'b1;
		tag_period_ticks <= p;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_period(p);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly aligned records with random content, some noise and cut-short records
	task automatic random_traffic(input int byte_goal, input int event_goal);
		int bytes_sent;
		int start_events;
		int kind;
		bytes_sent = 0;
		start_events = sb.events_predicted;
		while (bytes_sent < byte_goal || sb.events_predicted - start_events < event_goal) begin
			kind = $urandom_range(0, 19);
			if (kind < 2) begin
				repeat ($urandom_range(1, 4)) begin
					send_byte((kind == 0) ? 8'($urandom_range(0, 8'hF7)) : 8'($urandom));
					bytes_sent++;
				end
			end else if (kind == 2) begin
				// a header with a short tail, the next bytes finish it
				send_byte({sered_pkg::HeaderMark, 3'($urandom)});
				bytes_sent++;
				repeat ($urandom_range(0, 13)) begin
					send_byte(8'($urandom));
					bytes_sent++;
				end
			end else begin
				// realign before a well-formed record
				while (sb.in_frame) begin
					send_byte(8'($urandom_range(0, 8'hF7)));
					bytes_sent++;
				end
				if (kind < 8)
					send_frame(tag_frame(6'($urandom), pick_tag()));
				else
					send_frame(event_frame(6'($urandom), pick_channels(), 20'($urandom)));
				bytes_sent += 16;
			end
		end
	endtask

	initial begin : stimulus
		logic [19:0] p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		cfg_valid = 1'b0;
		tag_period_ticks = sered_pkg::PeriodReset;
		quiet = 1'b0;
		hold_requests = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// hunting drops bytes without the header mark
		send_byte(8'h00);
		send_byte(8'hF7);
		send_byte(8'h7F);
		// all-ones tag for the top module, header-like bytes inside the record
		send_frame({8'hFB, {15{8'hFF}}});
		// full-scale event on that module at the reset period
		send_frame({16{8'hFF}});
		// zero first sum, second sum full scale
		send_frame(event_frame(6'd1, {{4{12'hFFF}}, {4{12'h000}}}, 20'h00000));
		// first sum from channel A alone gives both ratios at one
		send_frame(event_frame(6'd2, {{7{12'h000}}, 12'hFFF}, 20'h00001));

		// period phases: top, zero, one, then random values
		for (int ph = 0; ph < PhaseCount; ph++) begin
			drain();
			case (ph)
				0: p = 20'hFFFFF;
				1: p = 20'h00000;
				2: p = 20'h00001;
				default: p = 20'($urandom_range(1, 20'hFFFFF));
			endcase
			write_period(p);
			if (ph == 3)
				hold_requests++;
			if (ph == PhaseCount - 1)
				quiet = 1'b1;
			send_frame({16{8'hFF}});
			// the long hold-off phase keeps offering bytes until the queue backs up
			random_traffic((ph == 3) ? 200 : 70, 3);
		end

		drain();
		if (sb.failures() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
src/sered_pkg.sv
src/sered_front.sv
src/sered_fifo.sv
src/sered_div.sv
src/sered_back.sv
src/scintillation_event_record_decoder.sv
tb/tb_top.sv
